[rtl/core/b64c_pkg.sv]
`timescale 1ns / 1ps
// package for the base64 stream codec: error codes, character constants
// and the sextet/alphabet mapping functions; no dependencies
package b64c_pkg;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CHAR    = 2'd1;
  localparam logic [1:0] ERR_LENGTH  = 2'd2;
  localparam logic [1:0] ERR_PADDING = 2'd3;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [2:0] ADDR_MODE = 3'd0;

  // character to {legal, six-bit value}; '=' maps to zero
  function automatic logic [6:0] sextet(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B) r = {1'b1, 6'd62};
    else if (c == 8'h2F) r = {1'b1, 6'd63};
    else if (c == CHAR_PAD) r = {1'b1, 6'd0};
    return r;
  endfunction

  // six-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) r = 8'h41 + {2'b00, v};
    else if (v < 6'd52) r = 8'h61 + {2'b00, v} - 8'd26;
    else if (v < 6'd62) r = 8'h30 + {2'b00, v} - 8'd52;
    else if (v == 6'd62) r = 8'h2B;
    else r = 8'h2F;
    return r;
  endfunction

endpackage

[rtl/core/base64_stream_codec.sv]
`timescale 1ns / 1ps
// base64 stream codec top level: input register, single-pass codec logic,
// four-entry result buffer and apb mode register; depends on b64c_pkg
//
//  channel  | direction | handshake        | payload
//  in_      | slave     | tvalid / tready  | tdata = data_in, tlast = last_in
//  out_     | master    | tvalid / tready  | tdata = data_out, tlast = last_out,
//           |           |                  | tuser = error
//  cfg_     | apb slave | psel/penable     | register 0 = mode (bit 0)
//
// an item waits in the input register until the result buffer is empty or
// its final result leaves; then its results (zero to four) load together
// and leave one per cycle while out_tready is high, so even an item with
// no results waits for them.
// synchronous active-low reset clears all stream state and mode.
module base64_stream_codec
  import b64c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_in
  input  logic       in_tlast,
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_out
  output logic       out_tlast,
  output logic [1:0] out_tuser,  // [1:0] error
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // mode register
  logic mode_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_MODE) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == 1'b0) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  // input register
  logic       in_vld_r;
  logic [7:0] in_data_r;
  logic       in_last_r;
  logic       load;

  // result buffer
  logic [7:0] buf_data_r [4];
  logic       buf_last_r [4];
  logic [1:0] buf_err_r  [4];
  logic [2:0] buf_cnt_r;

  // stream state
  logic [23:0] group_bits_r, group_bits_nxt;
  logic [1:0]  group_count_r, group_count_nxt;
  logic [2:0]  pad_run_r, pad_run_nxt;
  logic        discarding_r, discarding_nxt;
  logic [1:0]  error_code_r, error_code_nxt;

  // results of the item in the input register
  logic [7:0] res_data [4];
  logic       res_last [4];
  logic [1:0] res_err  [4];
  logic [2:0] res_cnt;

  logic out_take;

  assign out_tvalid = (buf_cnt_r != 3'd0);
  assign out_tdata  = buf_data_r[0];
  assign out_tlast  = buf_last_r[0];
  assign out_tuser  = buf_err_r[0];
  assign out_take   = out_tvalid && out_tready;

  // buffer accepts a new result set when empty or on its final result
  assign load      = in_vld_r && ((buf_cnt_r == 3'd0) || (buf_cnt_r == 3'd1 && out_take));
  assign in_tready = !in_vld_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // codec logic for one item
  always_comb begin
    logic [2:0]  ecnt;
    logic [1:0]  dcnt;
    logic [23:0] gb_enc;
    logic [23:0] gb_dec;
    logic [23:0] v;
    logic [6:0]  sx;
    logic [2:0]  pad_new;
    logic [1:0]  nbytes;

    group_bits_nxt  = group_bits_r;
    group_count_nxt = group_count_r;
    pad_run_nxt     = pad_run_r;
    discarding_nxt  = discarding_r;
    error_code_nxt  = error_code_r;
    res_cnt         = 3'd0;
    for (int k = 0; k < 4; k++) begin
      res_data[k] = 8'd0;
      res_last[k] = 1'b0;
      res_err[k]  = ERR_NONE;
    end

    ecnt    = {1'b0, group_count_r} + 3'd1;
    dcnt    = group_count_r + 2'd1;
    gb_enc  = {group_bits_r[15:0], in_data_r};
    sx      = sextet(in_data_r);
    gb_dec  = {group_bits_r[17:0], sx[5:0]};
    v       = (ecnt == 3'd1) ? (gb_enc << 16) : (gb_enc << 8);
    pad_new = (in_data_r == CHAR_PAD) ?
              ((pad_run_r == 3'd7) ? pad_run_r : pad_run_r + 3'd1) : 3'd0;
    nbytes  = 2'(3'd3 - pad_new);

    if (discarding_r) begin
      // dropping items until the end of the stream
      if (in_last_r) begin
        res_cnt        = 3'd1;
        res_last[0]    = 1'b1;
        res_err[0]     = error_code_r;
        group_bits_nxt = 24'd0;
        group_count_nxt = 2'd0;
        pad_run_nxt    = 3'd0;
        discarding_nxt = 1'b0;
        error_code_nxt = ERR_NONE;
      end
    end else if (mode_r == MODE_ENCODE) begin
      // encode: three bytes to four characters
      if (ecnt >= 3'd3) begin
        res_cnt = 3'd4;
        for (int k = 0; k < 4; k++) begin
          res_data[k] = enc_char(gb_enc[18 - 6 * k +: 6]);
        end
        res_last[3]     = in_last_r;
        group_bits_nxt  = 24'd0;
        group_count_nxt = 2'd0;
      end else begin
        group_bits_nxt  = gb_enc;
        group_count_nxt = ecnt[1:0];
        if (in_last_r) begin
          res_cnt = 3'd4;
          for (int k = 0; k < 4; k++) begin
            res_data[k] = (3'(k) <= ecnt) ? enc_char(v[18 - 6 * k +: 6]) : CHAR_PAD;
          end
          res_last[3] = 1'b1;
        end
      end
      if (in_last_r) begin
        group_bits_nxt  = 24'd0;
        group_count_nxt = 2'd0;
        pad_run_nxt     = 3'd0;
        error_code_nxt  = ERR_NONE;
      end
    end else begin
      // decode: four characters to three bytes
      pad_run_nxt = pad_new;
      if (!sx[6]) begin
        if (in_last_r) begin
          res_cnt         = 3'd1;
          res_last[0]     = 1'b1;
          res_err[0]      = (dcnt != 2'd0) ? ERR_LENGTH : ERR_CHAR;
          group_bits_nxt  = 24'd0;
          group_count_nxt = 2'd0;
          pad_run_nxt     = 3'd0;
          error_code_nxt  = ERR_NONE;
        end else begin
          discarding_nxt = 1'b1;
          error_code_nxt = ERR_CHAR;
        end
      end else begin
        group_bits_nxt  = gb_dec;
        group_count_nxt = dcnt;
        if (in_last_r) begin
          if (dcnt != 2'd0) begin
            res_cnt     = 3'd1;
            res_last[0] = 1'b1;
            res_err[0]  = ERR_LENGTH;
          end else if (pad_new >= 3'd3) begin
            res_cnt     = 3'd1;
            res_last[0] = 1'b1;
            res_err[0]  = ERR_PADDING;
          end else begin
            res_cnt = {1'b0, nbytes};
            for (int k = 0; k < 3; k++) begin
              res_data[k] = gb_dec[16 - 8 * k +: 8];
              res_last[k] = (2'(k) == nbytes - 2'd1);
            end
          end
          group_bits_nxt  = 24'd0;
          group_count_nxt = 2'd0;
          pad_run_nxt     = 3'd0;
          error_code_nxt  = ERR_NONE;
        end else if (dcnt == 2'd0) begin
          res_cnt = 3'd3;
          for (int k = 0; k < 3; k++) begin
            res_data[k] = gb_dec[16 - 8 * k +: 8];
          end
          group_bits_nxt = 24'd0;
        end
      end
    end
  end

  // stream state and buffer count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_bits_r  <= 24'd0;
      group_count_r <= 2'd0;
      pad_run_r     <= 3'd0;
      discarding_r  <= 1'b0;
      error_code_r  <= ERR_NONE;
      buf_cnt_r     <= 3'd0;
    end else begin
      if (load) begin
        group_bits_r  <= group_bits_nxt;
        group_count_r <= group_count_nxt;
        pad_run_r     <= pad_run_nxt;
        discarding_r  <= discarding_nxt;
        error_code_r  <= error_code_nxt;
        buf_cnt_r     <= res_cnt;
      end else if (out_take) begin
        buf_cnt_r <= buf_cnt_r - 3'd1;
      end
    end
  end

  // result buffer payload, shifts toward entry 0 as items leave
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 4; k++) begin
        buf_data_r[k] <= res_data[k];
        buf_last_r[k] <= res_last[k];
        buf_err_r[k]  <= res_err[k];
      end
    end else if (out_take) begin
      for (int k = 0; k < 3; k++) begin
        buf_data_r[k] <= buf_data_r[k + 1];
        buf_last_r[k] <= buf_last_r[k + 1];
        buf_err_r[k]  <= buf_err_r[k + 1];
      end
    end
  end

endmodule
